/* design/efd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_pkg: shared types and constants of the eeg frame decoder
// Frame layout constants, result kinds, the job record passed from the
// byte parser to the scaling engine and the configuration bundle.
// ----------------------------------------------------------------------------
package efd_pkg;

  localparam int DEF_MAX_CHIPS       = 4;
  localparam int DEF_TIMESTAMP_BYTES = 8;
  localparam int CHIP_CHANNELS       = 8;
  localparam int CH_SEL_W            = $clog2(CHIP_CHANNELS);
  localparam int SEQ_BYTES           = 4;
  localparam int CHIP_BYTES          = 3 + 3 * CHIP_CHANNELS;
  localparam int LEADOFF_LSB         = 12;
  localparam int MASK_SLOTS          = 32 / CHIP_CHANNELS;
  localparam logic [22:0] FULL_SCALE = 23'h7FFFFF;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int OUT_TDATA_W = 200;

  localparam logic KIND_CHANNEL = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [2:0]  chip_count;
    logic [4:0]  gain;
    logic [22:0] vref_microvolts;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [4:0]  channel_index;
    logic [23:0] raw_sample;
    logic [31:0] sequence_number;
    logic [63:0] frame_timestamp;
    logic [31:0] lead_off_mask;
    logic [31:0] dropped_count;
  } job_t;

  typedef struct packed {
    logic [1:0] n;
    job_t       a;
    job_t       b;
  } push_t;

endpackage

/* design/eeg_frame_decoder_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eeg_frame_decoder_unit: eeg converter frame decoder
// Decodes a byte stream of frames into scaled channel values and a frame
// summary per frame, with an apb register port for chip count, gain and
// reference voltage.
// ----------------------------------------------------------------------------
// usage
//   s_* carries one frame byte per transaction, s_tuser high on the first
//   byte of a new block resyncs the parser and drops any partial frame.
//   m_* carries results: tuser 0 channel value, tuser 1 frame summary with
//   tlast high. A byte that ends a sample and the frame gives the channel
//   value first, then the summary.
//   the parser takes a byte per cycle while the four entry job queue has
//   room for two jobs. the scaling engine works on one job at a time: a
//   channel value is loaded, multiplied, divided at two quotient bits per
//   step and put in the output register; a summary is loaded and put in
//   the output register. the engine takes its next job only after the
//   previous result has moved into the output register.
//   when m_tready is low the finished result waits in the output register,
//   the engine holds its next result and the parser fills the queue before
//   s_tready drops.
//   reset clears the frame state, the previous sequence number and sets
//   chip count 1, gain 1 and reference 0. write registers only when idle.
// ----------------------------------------------------------------------------
module eeg_frame_decoder_unit
  import efd_pkg::*;
#(
  parameter int MAX_CHIPS       = DEF_MAX_CHIPS,
  parameter int TIMESTAMP_BYTES = DEF_TIMESTAMP_BYTES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // data_byte
  input  logic                   s_tuser,   // chunk_start
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // channel_index, microvolts_q8, sequence_number, frame_timestamp,
  // lead_off_mask, dropped_count, zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tuser,   // kind
  output logic                   m_tlast    // frame_last
);

  localparam logic [1:0] REG_CHIP_COUNT = 2'd0;
  localparam logic [1:0] REG_GAIN       = 2'd1;
  localparam logic [1:0] REG_VREF       = 2'd2;

  cfg_t  cfg;
  logic  cfg_wr;
  push_t push;
  logic  room;
  logic  pop;
  job_t  head;
  logic  not_empty;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chip_count      <= 3'd1;
      cfg.gain            <= 5'd1;
      cfg.vref_microvolts <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_CHIP_COUNT: cfg.chip_count      <= pwdata[2:0];
        REG_GAIN:       cfg.gain            <= pwdata[4:0];
        REG_VREF:       cfg.vref_microvolts <= pwdata[22:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CHIP_COUNT: prdata = 32'(cfg.chip_count);
      REG_GAIN:       prdata = 32'(cfg.gain);
      REG_VREF:       prdata = 32'(cfg.vref_microvolts);
      default:        prdata = '0;
    endcase
  end

  efd_front #(
    .MAX_CHIPS       (MAX_CHIPS),
    .TIMESTAMP_BYTES (TIMESTAMP_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg      (cfg),
    .room     (room),
    .push     (push)
  );

  efd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  efd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .not_empty (not_empty),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

/* design/efd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_front: frame byte parser
// Tracks the byte position in the frame, assembles header fields, status
// words and samples, and hands sample and frame summary jobs to the queue.
// ----------------------------------------------------------------------------
module efd_front
  import efd_pkg::*;
#(
  parameter int MAX_CHIPS       = DEF_MAX_CHIPS,
  parameter int TIMESTAMP_BYTES = DEF_TIMESTAMP_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // data_byte
  input  logic       s_tuser,   // chunk_start
  input  cfg_t       cfg,
  input  logic       room,
  output push_t      push
);

  localparam int HEADER_BYTES = SEQ_BYTES + TIMESTAMP_BYTES;
  localparam int MAX_LEN      = HEADER_BYTES + MAX_CHIPS * CHIP_BYTES;
  localparam int POS_W        = $clog2(MAX_LEN + 1);
  localparam int LEN_W        = POS_W + 1;
  localparam int CHIP_W       = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;
  localparam int WORD_W       = $clog2(CHIP_CHANNELS + 1);

  logic [POS_W-1:0]  pos;
  logic [31:0]       seq;
  logic [63:0]       ts;
  logic [15:0]       wa;
  logic [31:0]       mask;
  logic [31:0]       prev;
  logic [1:0]        wbyte;
  logic [WORD_W-1:0] widx;
  logic [CHIP_W-1:0] chip;

  logic [POS_W-1:0]  pos_c, pos_next;
  logic [31:0]       seq_c, seq_upd, seq_next;
  logic [63:0]       ts_c, ts_upd, ts_next;
  logic [15:0]       wa_c, wa_next;
  logic [31:0]       mask_c, mask_upd, mask_next;
  logic [1:0]        wbyte_c, wbyte_next;
  logic [WORD_W-1:0] widx_c, widx_next;
  logic [CHIP_W-1:0] chip_c, chip_next;

  logic              take;
  logic [3:0]        chips;
  logic [LEN_W-1:0]  frame_len;
  logic [2:0]        ts_idx;
  logic [23:0]       word;
  logic [7:0]        ch_wide;
  logic              is_sample;
  logic              is_last;
  job_t              sample_job;
  job_t              summary_job;

  assign s_tready = room;
  assign take     = s_tvalid & s_tready;

  always_comb begin
    pos_c   = s_tuser ? '0 : pos;
    seq_c   = s_tuser ? '0 : seq;
    ts_c    = s_tuser ? '0 : ts;
    wa_c    = s_tuser ? '0 : wa;
    mask_c  = s_tuser ? '0 : mask;
    wbyte_c = s_tuser ? '0 : wbyte;
    widx_c  = s_tuser ? '0 : widx;
    chip_c  = s_tuser ? '0 : chip;

    chips = (4'(cfg.chip_count) > 4'(MAX_CHIPS)) ? 4'(MAX_CHIPS) : 4'(cfg.chip_count);
    frame_len = LEN_W'(HEADER_BYTES) + LEN_W'(chips * CHIP_BYTES);

    seq_upd    = seq_c;
    ts_upd     = ts_c;
    wa_next    = wa_c;
    mask_upd   = mask_c;
    wbyte_next = wbyte_c;
    widx_next  = widx_c;
    chip_next  = chip_c;
    is_sample  = 1'b0;
    word       = {wa_c, s_tdata};
    ts_idx     = 3'(pos_c - POS_W'(SEQ_BYTES));
    ch_wide    = 8'({chip_c, CH_SEL_W'(widx_c - WORD_W'(1))});

    if (pos_c < POS_W'(SEQ_BYTES)) begin
      seq_upd[{pos_c[1:0], 3'b000} +: 8] = s_tdata;
    end else if (pos_c < POS_W'(HEADER_BYTES)) begin
      ts_upd[{ts_idx, 3'b000} +: 8] = s_tdata;
    end else begin
      case (wbyte_c)
        2'd0: wa_next = {s_tdata, 8'h00};
        2'd1: wa_next = {wa_c[15:8], s_tdata};
        default: begin
          if (widx_c == '0) begin
            for (int c = 0; c < MASK_SLOTS; c++) begin
              if (32'(chip_c) == c) begin
                mask_upd[CHIP_CHANNELS*c +: 8] =
                  mask_c[CHIP_CHANNELS*c +: 8] | word[LEADOFF_LSB +: 8];
              end
            end
          end else begin
            is_sample = 1'b1;
          end
        end
      endcase
      if (wbyte_c == 2'd2) begin
        wbyte_next = '0;
        if (widx_c == WORD_W'(CHIP_CHANNELS)) begin
          widx_next = '0;
          chip_next = chip_c + 1'b1;
        end else begin
          widx_next = widx_c + 1'b1;
        end
      end else begin
        wbyte_next = wbyte_c + 1'b1;
      end
    end

    is_last = (LEN_W'(pos_c) + LEN_W'(1)) >= frame_len;

    sample_job                 = '0;
    sample_job.kind            = KIND_CHANNEL;
    sample_job.channel_index   = ch_wide[4:0];
    sample_job.raw_sample      = word;

    summary_job                 = '0;
    summary_job.kind            = KIND_SUMMARY;
    summary_job.sequence_number = seq_upd;
    summary_job.frame_timestamp = ts_upd;
    summary_job.lead_off_mask   = mask_upd;
    summary_job.dropped_count   = seq_upd - prev - 32'd1;

    push.n = take ? (2'(is_sample) + 2'(is_last)) : 2'd0;
    push.a = is_sample ? sample_job : summary_job;
    push.b = summary_job;

    if (is_last) begin
      pos_next   = '0;
      seq_next   = '0;
      ts_next    = '0;
      mask_next  = '0;
      wa_next    = '0;
      wbyte_next = '0;
      widx_next  = '0;
      chip_next  = '0;
    end else begin
      pos_next  = pos_c + 1'b1;
      seq_next  = seq_upd;
      ts_next   = ts_upd;
      mask_next = mask_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      seq   <= '0;
      ts    <= '0;
      wa    <= '0;
      mask  <= '0;
      prev  <= '0;
      wbyte <= '0;
      widx  <= '0;
      chip  <= '0;
    end else if (take) begin
      pos   <= pos_next;
      seq   <= seq_next;
      ts    <= ts_next;
      wa    <= wa_next;
      mask  <= mask_next;
      wbyte <= wbyte_next;
      widx  <= widx_next;
      chip  <= chip_next;
      if (is_last) begin
        prev <= seq_upd;
      end
    end
  end

endmodule

/* design/efd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_queue: job queue between parser and scaling engine
// Small register fifo taking up to two jobs a cycle, handing out one.
// ----------------------------------------------------------------------------
module efd_queue
  import efd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  room,
  input  logic  pop,
  output job_t  head,
  output logic  not_empty
);

  job_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QPTR_W-1:0] wr_ptr_b;

  assign room      = count <= QCNT_W'(QUEUE_DEPTH - 2);
  assign not_empty = count != '0;
  assign head      = entry[rd_ptr];
  assign wr_ptr_b  = wr_ptr + 1'b1;

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (push.n != 2'd0 && wr_ptr == QPTR_W'(i)) begin
        entry[i] <= push.a;
      end
      if (push.n == 2'd2 && wr_ptr_b == QPTR_W'(i)) begin
        entry[i] <= push.b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push.n) - QCNT_W'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd0 |-> count <= QCNT_W'(QUEUE_DEPTH - 2))
    else $error("job pushed without room for two");
  assert property (@(posedge clk) disable iff (rst) pop |-> count != '0)
    else $error("pop from empty queue");

endmodule

/* design/efd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efd_back: sample scaling engine and output register
// Scales samples to Q8 microvolts with a multiply and a two bit per cycle
// restoring divider, and drives the result stream.
// ----------------------------------------------------------------------------
module efd_back
  import efd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  job_t                   head,
  input  logic                   not_empty,
  output logic                   pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // channel_index, microvolts_q8, sequence_number, frame_timestamp,
  // lead_off_mask, dropped_count, zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tuser,   // kind
  output logic                   m_tlast    // frame_last
);

  localparam int QUOT_W    = 32;
  localparam int BITS_STEP = 2;
  localparam int DIV_STEPS = QUOT_W / BITS_STEP;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int DVS_W     = 28;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} state_t;

  state_t            state;
  job_t              job;
  logic              neg;
  logic [23:0]       mag;
  logic [DVS_W-1:0]  rem;
  logic [QUOT_W-1:0] quot;
  logic [DVS_W-1:0]  dvs;
  logic [STEP_W-1:0] step;

  logic [4:0]        g;
  logic [46:0]       prod;
  logic [DVS_W-1:0]  dvs_calc;
  logic [DVS_W:0]    trial;
  logic [DVS_W-1:0]  rem_w;
  logic [QUOT_W-1:0] quot_w;
  logic [31:0]       uv;
  logic              out_free;

  assign pop      = (state == S_IDLE) && not_empty;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    g        = (cfg.gain == 5'd0) ? 5'd1 : cfg.gain;
    prod     = 47'(mag) * 47'(cfg.vref_microvolts);
    dvs_calc = 28'(DVS_W'(g) * DVS_W'(FULL_SCALE));
    uv       = neg ? (~quot + 32'd1) : quot;
    rem_w    = rem;
    quot_w   = quot;
    trial    = '0;
    for (int i = 0; i < BITS_STEP; i++) begin
      trial  = {rem_w, quot_w[QUOT_W-1]};
      quot_w = {quot_w[QUOT_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem_w     = DVS_W'(trial - {1'b0, dvs});
        quot_w[0] = 1'b1;
      end else begin
        rem_w = trial[DVS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (not_empty) begin
            job  <= head;
            neg  <= head.raw_sample[23];
            mag  <= head.raw_sample[23] ? (~head.raw_sample + 24'd1) : head.raw_sample;
            quot <= '0;
            state <= (head.kind == KIND_SUMMARY) ? S_DONE : S_MUL;
          end
        end
        S_MUL: begin
          rem   <= DVS_W'(prod[46:24]);
          quot  <= {prod[23:0], 8'h00};
          dvs   <= dvs_calc;
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem  <= rem_w;
          quot <= quot_w;
          step <= step + 1'b1;
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tuser  <= job.kind;
            m_tlast  <= job.kind == KIND_SUMMARY;
            m_tdata  <= OUT_TDATA_W'({job.dropped_count, job.lead_off_mask,
                                      job.frame_timestamp, job.sequence_number,
                                      (job.kind == KIND_SUMMARY) ? 32'd0 : uv,
                                      job.channel_index});
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> m_tlast == m_tuser)
    else $error("frame end flag differs from result kind");
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_SUMMARY) |-> m_tdata[36:0] == '0)
    else $error("summary carries channel data");
  assert property (@(posedge clk) disable iff (rst) state == S_MUL |=> state == S_DIV)
    else $error("divider not started after multiply");

endmodule
